### rtl/pli_pkg.sv
// Package for the piecewise linear interpolator: request, status and select
// codes, the controller/datapath command and status structs. No dependencies.
package pli_pkg;

    localparam int DATA_W    = 32;
    localparam int ENTRY_W   = 2 * DATA_W;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // table write data select
    localparam logic WR_SEL_RD  = 1'b0;
    localparam logic WR_SEL_NEW = 1'b1;

    // result select
    localparam logic [1:0] RES_ZERO  = 2'd0;
    localparam logic [1:0] RES_RD    = 2'd1;
    localparam logic [1:0] RES_ARITH = 2'd2;

    typedef struct packed {
        logic       load_req;
        logic       wr_en;
        logic       wr_sel;
        logic       load_prev;
        logic       load_cur;
        logic       load_diff;
        logic       load_mul;
        logic       div_step;
        logic       res_load;
        logic [1:0] res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic rd_gt_x;   // table x read back is above the request x
        logic rd_ge_x;   // table x read back is at or above the request x
    } dp_stat_t;

endpackage

### rtl/piecewise_linear_interpolator_top.sv
// Top level of the piecewise linear interpolator: joins the controller and the
// datapath. Depends on pli_pkg, pli_ctrl, pli_datapath (and pli_ram beneath it).
//
//  channel   | strobe / hold   | payload                         | beat taken when
//  ----------+-----------------+---------------------------------+--------------------
//  request   | start / busy    | req_type, x_value, y_value      | start high, busy low
//  result    | done            | y_out, status                   | every cycle done high
//
// Per beat: clear, full insert, unused code and empty query finish straight from idle;
// an insert shifts up each entry with x above the new x, then writes the new point,
// one entry moved per cycle over the single RAM read/write port pair; a query
// that lands on an end point returns that entry's y, and an interior query scans
// to the segment's upper breakpoint, then runs the 32-step restoring divide.
// Reset clears the point count and the controller; the table itself is left
// as it is and only entries below the count are ever read.
// The result strobe lasts one cycle and busy falls with it: the receiver cannot
// stall, and a new request may be started in the very cycle done is high.
module piecewise_linear_interpolator_top
    import pli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [REQ_W-1:0]         req_type,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] y_value,
    output logic                     done,
    output logic signed [DATA_W-1:0] y_out,
    output logic [STAT_W-1:0]        status
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // command and status between the two halves
    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // sequence each request: decode, walk the table, step the divider
    pli_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .busy     (busy),
        .done     (done),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    // hold the table, the segment found and the arithmetic on it
    pli_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .x_value (x_value),
        .y_value (y_value),
        .stat    (stat),
        .y_out   (y_out)
    );

endmodule

### rtl/pli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/pli_datapath.sv
// Datapath of the interpolator: breakpoint RAM, request and segment registers,
// multiplier, restoring divider and result register. Depends on pli_pkg, pli_ram.
module pli_datapath
    import pli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           clk,
    input  dp_cmd_t                        cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  logic signed [DATA_W-1:0]       x_value,
    input  logic signed [DATA_W-1:0]       y_value,
    output dp_stat_t                       stat,
    output logic signed [DATA_W-1:0]       y_out
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [ENTRY_W-1:0]        rd_data;
    logic [ENTRY_W-1:0]        wr_data;
    logic signed [DATA_W-1:0]  rd_x;
    logic signed [DATA_W-1:0]  rd_y;

    logic signed [DATA_W-1:0]  x_q_reg;
    logic signed [DATA_W-1:0]  y_q_reg;
    logic signed [DATA_W-1:0]  prev_x_reg;
    logic signed [DATA_W-1:0]  prev_y_reg;
    logic signed [DATA_W-1:0]  cur_x_reg;
    logic signed [DATA_W-1:0]  cur_y_reg;
    logic [DATA_W-1:0]         num_reg;
    logic [DATA_W-1:0]         den_reg;
    logic [DATA_W-1:0]         mag_reg;
    logic                      neg_reg;
    logic [DATA_W-1:0]         rem_reg;
    logic [DATA_W-1:0]         quo_reg;
    logic signed [DATA_W-1:0]  y_out_reg;

    logic [DATA_W:0]           num_next;
    logic [DATA_W:0]           den_next;
    logic [DATA_W:0]           dy_next;
    logic [DATA_W:0]           dy_neg;
    logic [ENTRY_W-1:0]        prod_next;
    logic [DATA_W:0]           trial;
    logic                      qbit;
    logic [DATA_W:0]           sum_next;
    logic signed [DATA_W-1:0]  y_out_next;

    pli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_x = $signed(rd_data[ENTRY_W-1:DATA_W]);
    assign rd_y = $signed(rd_data[DATA_W-1:0]);

    assign wr_data = (cmd.wr_sel == WR_SEL_NEW) ? {x_q_reg, y_q_reg} : rd_data;

    assign stat.rd_gt_x = (rd_x > x_q_reg);
    assign stat.rd_ge_x = (rd_x >= x_q_reg);

    // segment differences; x0 < x <= x1 keeps both x spans positive
    assign num_next = {x_q_reg[DATA_W-1], x_q_reg} - {prev_x_reg[DATA_W-1], prev_x_reg};
    assign den_next = {cur_x_reg[DATA_W-1], cur_x_reg} - {prev_x_reg[DATA_W-1], prev_x_reg};
    assign dy_next  = {cur_y_reg[DATA_W-1], cur_y_reg} - {prev_y_reg[DATA_W-1], prev_y_reg};
    assign dy_neg   = (~dy_next) + 1'b1;

    assign prod_next = num_reg * mag_reg;

    // one restoring step: remainder stays below the divisor
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    assign sum_next = neg_reg ? ({prev_y_reg[DATA_W-1], prev_y_reg} - {1'b0, quo_reg})
                              : ({prev_y_reg[DATA_W-1], prev_y_reg} + {1'b0, quo_reg});

    always_comb
    begin
        case (cmd.res_sel)
            RES_RD:    y_out_next = rd_y;
            RES_ARITH: y_out_next = $signed(sum_next[DATA_W-1:0]);
            default:   y_out_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            x_q_reg <= x_value;
            y_q_reg <= y_value;
        end
        if (cmd.load_prev)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
        if (cmd.load_cur)
        begin
            cur_x_reg <= rd_x;
            cur_y_reg <= rd_y;
        end
        if (cmd.load_diff)
        begin
            num_reg <= num_next[DATA_W-1:0];
            den_reg <= den_next[DATA_W-1:0];
            neg_reg <= dy_next[DATA_W];
            mag_reg <= dy_next[DATA_W] ? dy_neg[DATA_W-1:0] : dy_next[DATA_W-1:0];
        end
        if (cmd.load_mul)
        begin
            rem_reg <= prod_next[ENTRY_W-1:DATA_W];
            quo_reg <= prod_next[DATA_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? DATA_W'(trial - {1'b0, den_reg}) : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], qbit};
        end
        if (cmd.res_load)
        begin
            y_out_reg <= y_out_next;
        end
    end

    assign y_out = y_out_reg;

endmodule

### rtl/pli_ctrl.sv
// Controller of the interpolator: request decode, table insert and scan
// sequencing, divider step count, point count and result strobe. Depends on pli_pkg.
module pli_ctrl
    import pli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [REQ_W-1:0]                 req_type,
    input  dp_stat_t                         stat,
    output logic                             busy,
    output logic                             done,
    output logic [STAT_W-1:0]                status,
    output dp_cmd_t                          cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
    output logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SHIFT   = 4'd1;
    localparam logic [3:0] ST_PUT     = 4'd2;
    localparam logic [3:0] ST_FIRST   = 4'd3;
    localparam logic [3:0] ST_LAST    = 4'd4;
    localparam logic [3:0] ST_SCAN    = 4'd5;
    localparam logic [3:0] ST_DIFF    = 4'd6;
    localparam logic [3:0] ST_MUL     = 4'd7;
    localparam logic [3:0] ST_DIV     = 4'd8;
    localparam logic [3:0] ST_FIN     = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  done_reg, done_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [AW-1:0]         last_idx;

    assign last_idx = AW'(count_reg - 1'b1);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        div_cnt_next = div_cnt_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        cmd          = '0;
        rd_addr      = '0;
        wr_addr      = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    unique case (req_type)
                        REQ_CLEAR:
                        begin
                            count_next   = '0;
                            done_next    = 1'b1;
                            status_next  = STAT_OK;
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_ZERO;
                        end
                        REQ_INSERT:
                        begin
                            if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                done_next    = 1'b1;
                                status_next  = STAT_FULL;
                                cmd.res_load = 1'b1;
                                cmd.res_sel  = RES_ZERO;
                            end
                            else if (count_reg == '0)
                            begin
                                idx_next   = '0;
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                idx_next   = AW'(count_reg);
                                rd_addr    = last_idx;
                                state_next = ST_SHIFT;
                            end
                        end
                        REQ_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next    = 1'b1;
                                status_next  = STAT_EMPTY;
                                cmd.res_load = 1'b1;
                                cmd.res_sel  = RES_ZERO;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                state_next = ST_FIRST;
                            end
                        end
                        default:
                        begin
                            done_next    = 1'b1;
                            status_next  = STAT_OK;
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_ZERO;
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                // move larger entries up one place, reading the next one down
                if (stat.rd_gt_x)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_SEL_RD;
                    idx_next   = AW'(idx_reg - 1'b1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        rd_addr = AW'(idx_reg - AW'(2));
                    end
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_SEL_NEW;
                count_next   = CW'(count_reg + 1'b1);
                done_next    = 1'b1;
                status_next  = STAT_OK;
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_ZERO;
                state_next   = ST_IDLE;
            end
            ST_FIRST:
            begin
                cmd.load_prev = 1'b1;
                if (count_reg == CW'(1) || stat.rd_ge_x)
                begin
                    done_next    = 1'b1;
                    status_next  = STAT_OK;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_RD;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    rd_addr    = last_idx;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (!stat.rd_gt_x)
                begin
                    done_next    = 1'b1;
                    status_next  = STAT_OK;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_RD;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    idx_next   = AW'(1);
                    rd_addr    = AW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.rd_ge_x)
                begin
                    cmd.load_cur = 1'b1;
                    state_next   = ST_DIFF;
                end
                else
                begin
                    cmd.load_prev = 1'b1;
                    idx_next      = AW'(idx_reg + 1'b1);
                    rd_addr       = AW'(idx_reg + 1'b1);
                end
            end
            ST_DIFF:
            begin
                cmd.load_diff = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.load_mul = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = DIV_CNT_W'(div_cnt_reg + 1'b1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                done_next    = 1'b1;
                status_next  = STAT_OK;
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_ARITH;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            count_reg   <= '0;
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
            status_reg  <= STAT_OK;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            div_cnt_reg <= div_cnt_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

endmodule
